/* rtl/core/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Word formats and request types for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

	// fixed-point format of matrix elements and quaternion components
	localparam int WORD_W = 16;
	localparam int FRAC_W = 14;

	// branch codes carried on the pivot field
	localparam logic [1:0] PIV_TRACE = 2'd0;
	localparam logic [1:0] PIV_X     = 2'd1;
	localparam logic [1:0] PIV_Y     = 2'd2;
	localparam logic [1:0] PIV_Z     = 2'd3;

	typedef struct packed {
		logic signed [WORD_W-1:0] m00;
		logic signed [WORD_W-1:0] m01;
		logic signed [WORD_W-1:0] m02;
		logic signed [WORD_W-1:0] m10;
		logic signed [WORD_W-1:0] m11;
		logic signed [WORD_W-1:0] m12;
		logic signed [WORD_W-1:0] m20;
		logic signed [WORD_W-1:0] m21;
		logic signed [WORD_W-1:0] m22;
	} matrix_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] quat_w;
		logic signed [WORD_W-1:0] quat_x;
		logic signed [WORD_W-1:0] quat_y;
		logic signed [WORD_W-1:0] quat_z;
		logic        [1:0]        pivot;
		logic                     degenerate;
	} quat_t;

endpackage

/* rtl/core/rotation_matrix_to_quaternion_top.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Converts a 3x3 rotation matrix in signed fixed point to a quaternion,
// picking the trace branch or the largest diagonal element as pivot.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  matrix_t (m00 .. m22)
// out      output     out_valid/ out_stall quat_t (w, x, y, z, pivot, degenerate)
//
// One request per cycle while the output is not stalled. The pipeline depth is
// set by the digit-serial square root (one root bit per stage) followed by the
// restoring dividers (one quotient bit per stage, three in parallel). Reset
// clears only the valid bits. A stall on the output freezes the whole pipeline
// and is passed back as in_stall.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
	import rmq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  matrix_t in_data,
	output logic    out_valid,
	input  logic    out_stall,
	output quat_t   out_data
);

	localparam int W     = WORD_W;
	localparam int F     = FRAC_W;
	localparam int RBITS = ((W > F) ? W : F + 1) + 2;
	localparam int XW    = RBITS + F - 2;
	localparam int XWE   = XW + (XW % 2);
	localparam int SB    = XWE / 2;
	localparam int RMW   = SB + 3;
	localparam int DW    = W + F;
	localparam int EW    = W + F + SB + 2;
	localparam logic signed [RBITS-1:0] ONE_Q = RBITS'(1) << F;
	localparam logic [W:0] SMAX_M = (W+1)'((1 << (W - 1)) - 1);

	typedef struct packed {
		logic [1:0]      piv;
		logic            degen;
		logic signed [W:0] n0;
		logic signed [W:0] n1;
		logic signed [W:0] n2;
	} side_t;

	logic en;

	// pipeline advances unless a finished result is held
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: trace, pivot choice, radicand and numerators
	logic signed [RBITS-1:0] a00, a11, a22, tr_c, r_c;
	logic [1:0] piv_c;
	logic signed [W:0] n0_c, n1_c, n2_c;
	logic signed [W:0] e01, e02, e10, e12, e20, e21;

	always_comb begin
		a00 = RBITS'(in_data.m00);
		a11 = RBITS'(in_data.m11);
		a22 = RBITS'(in_data.m22);
		e01 = (W+1)'(in_data.m01);
		e02 = (W+1)'(in_data.m02);
		e10 = (W+1)'(in_data.m10);
		e12 = (W+1)'(in_data.m12);
		e20 = (W+1)'(in_data.m20);
		e21 = (W+1)'(in_data.m21);
		tr_c = a00 + a11 + a22;
		if (tr_c > 0) begin
			piv_c = PIV_TRACE;
			r_c   = tr_c + ONE_Q;
			n0_c  = e21 - e12;
			n1_c  = e02 - e20;
			n2_c  = e10 - e01;
		end else if (a11 > a00) begin
			if (a22 > a11) begin
				piv_c = PIV_Z;
				r_c   = a22 - a00 - a11 + ONE_Q;
				n0_c  = e10 - e01;
				n1_c  = e02 + e20;
				n2_c  = e12 + e21;
			end else begin
				piv_c = PIV_Y;
				r_c   = a11 - a22 - a00 + ONE_Q;
				n0_c  = e02 - e20;
				n1_c  = e21 + e12;
				n2_c  = e01 + e10;
			end
		end else if (a22 > a00) begin
			piv_c = PIV_Z;
			r_c   = a22 - a00 - a11 + ONE_Q;
			n0_c  = e10 - e01;
			n1_c  = e02 + e20;
			n2_c  = e12 + e21;
		end else begin
			piv_c = PIV_X;
			r_c   = a00 - a11 - a22 + ONE_Q;
			n0_c  = e21 - e12;
			n1_c  = e10 + e01;
			n2_c  = e20 + e02;
		end
	end

	logic            v_s1;
	side_t           side_s1;
	logic [XWE-1:0]  x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.piv   <= piv_c;
			side_s1.degen <= (r_c <= 0);
			side_s1.n0    <= n0_c;
			side_s1.n1    <= n1_c;
			side_s1.n2    <= n2_c;
			x_s1          <= (r_c <= 0) ? '0 : (XWE'($unsigned(r_c)) << (F - 2));
		end
	end

	// stage 2: square root, one root bit per stage
	logic            sq_v_s2    [0:SB];
	side_t           sq_side_s2 [0:SB];
	logic [XWE-1:0]  sq_x_s2    [0:SB];
	logic [RMW-1:0]  sq_rem_s2  [0:SB];
	logic [SB-1:0]   sq_root_s2 [0:SB];

	assign sq_v_s2[0]    = v_s1;
	assign sq_side_s2[0] = side_s1;
	assign sq_x_s2[0]    = x_s1;
	assign sq_rem_s2[0]  = '0;
	assign sq_root_s2[0] = '0;

	for (genvar k = 0; k < SB; k++) begin : g_sqrt
		logic [RMW-1:0] rem_t, trial;

		always_comb begin
			rem_t = {sq_rem_s2[k][RMW-3:0], sq_x_s2[k][XWE-1 -: 2]};
			trial = {1'b0, sq_root_s2[k], 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s2[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s2[k+1] <= sq_v_s2[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side_s2[k+1] <= sq_side_s2[k];
				sq_x_s2[k+1]    <= sq_x_s2[k] << 2;
				if (rem_t >= trial) begin
					sq_rem_s2[k+1]  <= rem_t - trial;
					sq_root_s2[k+1] <= {sq_root_s2[k][SB-2:0], 1'b1};
				end else begin
					sq_rem_s2[k+1]  <= rem_t;
					sq_root_s2[k+1] <= {sq_root_s2[k][SB-2:0], 1'b0};
				end
			end
		end
	end

	// stage 3: round root to nearest
	logic          v_s3;
	side_t         side_s3;
	logic [SB:0]   c_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v_s2[SB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= sq_side_s2[SB];
			c_s3    <= (SB+1)'(sq_root_s2[SB])
			           + (SB+1)'(sq_rem_s2[SB] > RMW'(sq_root_s2[SB]));
		end
	end

	// stage 4: dividends with rounding offset, overflow check
	logic [W:0]    mag0_c, mag1_c, mag2_c;
	logic [DW-1:0] d0_c, d1_c, d2_c;
	logic [EW-1:0] cw_c;

	always_comb begin
		mag0_c = side_s3.n0[W] ? (W+1)'(-side_s3.n0) : (W+1)'(side_s3.n0);
		mag1_c = side_s3.n1[W] ? (W+1)'(-side_s3.n1) : (W+1)'(side_s3.n1);
		mag2_c = side_s3.n2[W] ? (W+1)'(-side_s3.n2) : (W+1)'(side_s3.n2);
		d0_c   = (DW'(mag0_c) << (F - 2)) + DW'(c_s3 >> 1);
		d1_c   = (DW'(mag1_c) << (F - 2)) + DW'(c_s3 >> 1);
		d2_c   = (DW'(mag2_c) << (F - 2)) + DW'(c_s3 >> 1);
		cw_c   = EW'(c_s3) << W;
	end

	logic          dv_v_s4   [0:W];
	side_t         dv_side_s4[0:W];
	logic [SB:0]   dv_c_s4   [0:W];
	logic [DW-1:0] dv_r0_s4  [0:W];
	logic [DW-1:0] dv_r1_s4  [0:W];
	logic [DW-1:0] dv_r2_s4  [0:W];
	logic [W-1:0]  dv_q0_s4  [0:W];
	logic [W-1:0]  dv_q1_s4  [0:W];
	logic [W-1:0]  dv_q2_s4  [0:W];
	logic [2:0]    dv_ovf_s4 [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s4[0] <= 1'b0;
		end else if (en) begin
			dv_v_s4[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_s4[0] <= side_s3;
			dv_c_s4[0]    <= c_s3;
			dv_r0_s4[0]   <= d0_c;
			dv_r1_s4[0]   <= d1_c;
			dv_r2_s4[0]   <= d2_c;
			dv_q0_s4[0]   <= '0;
			dv_q1_s4[0]   <= '0;
			dv_q2_s4[0]   <= '0;
			dv_ovf_s4[0]  <= {EW'(d2_c) >= cw_c, EW'(d1_c) >= cw_c, EW'(d0_c) >= cw_c};
		end
	end

	// restoring dividers, one quotient bit per stage, msb first
	for (genvar j = 0; j < W; j++) begin : g_div
		localparam int B = W - 1 - j;
		logic [EW-1:0] dsh;
		logic          t0, t1, t2;

		always_comb begin
			dsh = EW'(dv_c_s4[j]) << B;
			t0  = EW'(dv_r0_s4[j]) >= dsh;
			t1  = EW'(dv_r1_s4[j]) >= dsh;
			t2  = EW'(dv_r2_s4[j]) >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s4[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s4[j+1] <= dv_v_s4[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s4[j+1] <= dv_side_s4[j];
				dv_c_s4[j+1]    <= dv_c_s4[j];
				dv_ovf_s4[j+1]  <= dv_ovf_s4[j];
				dv_r0_s4[j+1]   <= t0 ? DW'(EW'(dv_r0_s4[j]) - dsh) : dv_r0_s4[j];
				dv_r1_s4[j+1]   <= t1 ? DW'(EW'(dv_r1_s4[j]) - dsh) : dv_r1_s4[j];
				dv_r2_s4[j+1]   <= t2 ? DW'(EW'(dv_r2_s4[j]) - dsh) : dv_r2_s4[j];
				dv_q0_s4[j+1]   <= dv_q0_s4[j] | (W'(t0) << B);
				dv_q1_s4[j+1]   <= dv_q1_s4[j] | (W'(t1) << B);
				dv_q2_s4[j+1]   <= dv_q2_s4[j] | (W'(t2) << B);
			end
		end
	end

	// stage 5: sign, saturation and routing to components
	function automatic logic signed [W-1:0] sat_q(logic neg, logic ovf, logic [W-1:0] q);
		logic [W:0] m;
		m = {1'b0, q};
		if (neg) begin
			if (ovf || m > SMAX_M + 1'b1) begin
				sat_q = {1'b1, {(W-1){1'b0}}};
			end else begin
				sat_q = W'(-m);
			end
		end else begin
			if (ovf || m > SMAX_M) begin
				sat_q = {1'b0, {(W-1){1'b1}}};
			end else begin
				sat_q = W'(m);
			end
		end
	endfunction

	side_t                  so;
	logic signed [W-1:0]    s0_c, s1_c, s2_c, sc_c;
	quat_t                  res_c;

	always_comb begin
		so   = dv_side_s4[W];
		s0_c = sat_q(so.n0[W], dv_ovf_s4[W][0], dv_q0_s4[W]);
		s1_c = sat_q(so.n1[W], dv_ovf_s4[W][1], dv_q1_s4[W]);
		s2_c = sat_q(so.n2[W], dv_ovf_s4[W][2], dv_q2_s4[W]);
		sc_c = ((SB+1 > W - 1) && (dv_c_s4[W] > (SB+1)'(SMAX_M)))
		       ? {1'b0, {(W-1){1'b1}}} : W'(dv_c_s4[W]);
		res_c.pivot      = so.piv;
		res_c.degenerate = so.degen;
		case (so.piv)
			PIV_TRACE: begin
				res_c.quat_w = sc_c;
				res_c.quat_x = s0_c;
				res_c.quat_y = s1_c;
				res_c.quat_z = s2_c;
			end
			PIV_X: begin
				res_c.quat_w = s0_c;
				res_c.quat_x = sc_c;
				res_c.quat_y = s1_c;
				res_c.quat_z = s2_c;
			end
			PIV_Y: begin
				res_c.quat_w = s0_c;
				res_c.quat_x = s2_c;
				res_c.quat_y = sc_c;
				res_c.quat_z = s1_c;
			end
			default: begin
				res_c.quat_w = s0_c;
				res_c.quat_x = s1_c;
				res_c.quat_y = s2_c;
				res_c.quat_z = sc_c;
			end
		endcase
		if (so.degen) begin
			res_c.quat_w = '0;
			res_c.quat_x = '0;
			res_c.quat_y = '0;
			res_c.quat_z = '0;
		end
	end

	logic  v_s5;
	quat_t res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_v_s4[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= res_c;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the matrix to quaternion converter: a table of directed matrices
// (identity, axis turns, trace and pivot branches, degenerate and saturating
// inputs) followed by random rotation-like and raw matrices, each result
// compared field by field with an exact integer model of the conversion.
// ----------------------------------------------------------------------------
module tb_top;
	import rmq_pkg::*;

	localparam int N_RANDOM = 1930;
	localparam int DRAIN_CYCLES = 80;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	matrix_t in_data;
	logic    out_valid;
	logic    out_stall;
	quat_t   out_data;

	rotation_matrix_to_quaternion_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// directed stimulus row; has_quat marks a typed-in expected result
	typedef struct {
		matrix_t m;
		logic    has_quat;
		quat_t   q;
	} dir_row_t;

	quat_t    quat_queue[$];
	int       n_errors;
	int       n_requests;
	int       n_results;
	int       n_degenerate;
	int       pivot_hits[4];
	bit       calm;
	bit       hold_off;
	bit       sender_done;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// signed clamp to the word range
	function automatic logic signed [WORD_W-1:0] clamp_word(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (WORD_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi[WORD_W-1:0];
		if (v < lo) return lo[WORD_W-1:0];
		return v[WORD_W-1:0];
	endfunction

	// rounded square root of r scaled by 2^(FRAC_W-2)
	function automatic longint root_scaled(longint r);
		longint x;
		longint c;
		longint step;
		x = r <<< (FRAC_W - 2);
		c = 0;
		for (step = longint'(1) <<< 31; step > 0; step = step >>> 1)
			if ((c + step) * (c + step) <= x) c = c + step;
		if (x - c * c > c) c = c + 1;
		return c;
	endfunction

	// num * 2^(FRAC_W-2) / c, rounded with ties away from zero
	function automatic longint div_scaled(longint num, longint c);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = ((mag <<< (FRAC_W - 2)) + (c >>> 1)) / c;
		return (num < 0) ? -q : q;
	endfunction

	// expected quaternion of one matrix
	function automatic quat_t quat_of(matrix_t m);
		longint a[3][3];
		longint q[4];
		longint tr;
		longint r;
		longint c;
		int     i;
		int     j;
		int     k;
		quat_t  res;
		a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
		a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
		a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
		q = '{0, 0, 0, 0};
		res.degenerate = 1'b0;
		tr = a[0][0] + a[1][1] + a[2][2];
		if (tr > 0) begin
			res.pivot = PIV_TRACE;
			c = root_scaled(tr + (longint'(1) <<< FRAC_W));
			q[0] = c;
			q[1] = div_scaled(a[2][1] - a[1][2], c);
			q[2] = div_scaled(a[0][2] - a[2][0], c);
			q[3] = div_scaled(a[1][0] - a[0][1], c);
		end else begin
			i = 0;
			if (a[1][1] > a[0][0]) i = 1;
			if (a[2][2] > a[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			res.pivot = (i == 0) ? PIV_X : (i == 1) ? PIV_Y : PIV_Z;
			r = a[i][i] - a[j][j] - a[k][k] + (longint'(1) <<< FRAC_W);
			if (r <= 0) begin
				res.degenerate = 1'b1;
			end else begin
				c = root_scaled(r);
				q[1 + i] = c;
				q[0] = div_scaled(a[k][j] - a[j][k], c);
				q[1 + j] = div_scaled(a[j][i] + a[i][j], c);
				q[1 + k] = div_scaled(a[k][i] + a[i][k], c);
			end
		end
		res.quat_w = clamp_word(q[0]);
		res.quat_x = clamp_word(q[1]);
		res.quat_y = clamp_word(q[2]);
		res.quat_z = clamp_word(q[3]);
		return res;
	endfunction

	function automatic matrix_t mat(int e00, int e01, int e02, int e10, int e11,
			int e12, int e20, int e21, int e22);
		matrix_t m;
		m.m00 = e00[WORD_W-1:0]; m.m01 = e01[WORD_W-1:0]; m.m02 = e02[WORD_W-1:0];
		m.m10 = e10[WORD_W-1:0]; m.m11 = e11[WORD_W-1:0]; m.m12 = e12[WORD_W-1:0];
		m.m20 = e20[WORD_W-1:0]; m.m21 = e21[WORD_W-1:0]; m.m22 = e22[WORD_W-1:0];
		return m;
	endfunction

	function automatic quat_t quat(int w, int x, int y, int z, logic [1:0] p, logic d);
		quat_t q;
		q.quat_w = w[WORD_W-1:0]; q.quat_x = x[WORD_W-1:0];
		q.quat_y = y[WORD_W-1:0]; q.quat_z = z[WORD_W-1:0];
		q.pivot = p; q.degenerate = d;
		return q;
	endfunction

	// random matrix: mostly entries within +-1.0, some with a negative diagonal, some raw noise
	function automatic matrix_t random_matrix();
		matrix_t      m;
		int           kind;
		logic [159:0] raw;
		kind = $urandom_range(0, 9);
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		m = raw[$bits(matrix_t)-1:0];
		if (kind < 6) begin
			m.m00 = WORD_W'($signed($urandom_range(0, 32768)) - 16384);
			m.m01 = WORD_W'($signed($urandom_range(0, 32768)) - 16384);
			m.m02 = WORD_W'($signed($urandom_range(0, 32768)) - 16384);
			m.m10 = WORD_W'($signed($urandom_range(0, 32768)) - 16384);
			m.m11 = WORD_W'($signed($urandom_range(0, 32768)) - 16384);
			m.m12 = WORD_W'($signed($urandom_range(0, 32768)) - 16384);
			m.m20 = WORD_W'($signed($urandom_range(0, 32768)) - 16384);
			m.m21 = WORD_W'($signed($urandom_range(0, 32768)) - 16384);
			m.m22 = WORD_W'($signed($urandom_range(0, 32768)) - 16384);
		end else if (kind < 8) begin
			// non-positive diagonal to exercise pivots (kind 7 makes m11 non-negative)
			m.m00 = WORD_W'(-$signed({1'b0, $urandom_range(0, 32767)}));
			m.m11 = WORD_W'(-$signed({1'b0, $urandom_range(0, 32767)}));
			m.m22 = WORD_W'(-$signed({1'b0, $urandom_range(0, 32767)}));
			if (kind == 7) m.m11 = WORD_W'($urandom_range(0, 32767));
		end
		return m;
	endfunction

	// send one request and record its expected quaternion
	task automatic send_request(matrix_t m);
		in_valid <= 1'b1;
		in_data  <= m;
		quat_queue.push_back(quat_of(m));
		do @(posedge clk); while (in_stall);
		n_requests++;
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
	endtask

	// sender
	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		int       n;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		hold_off = 1'b0;
		sender_done = 1'b0;
		n_errors = 0;
		n_requests = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// identity: w = 1.0
		rows.push_back('{mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1,
			quat(16384, 0, 0, 0, PIV_TRACE, 1'b0)});
		// half turn about x, y, z: pivot branches
		rows.push_back('{mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b1,
			quat(0, 16384, 0, 0, PIV_X, 1'b0)});
		rows.push_back('{mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1'b1,
			quat(0, 0, 16384, 0, PIV_Y, 1'b0)});
		rows.push_back('{mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b1,
			quat(0, 0, 0, 16384, PIV_Z, 1'b0)});
		// all zero: trace zero, radicand one
		rows.push_back('{mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0,
			quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		// negative and extreme diagonals with ties
		rows.push_back('{mat(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767), 1'b0,
			quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		rows.push_back('{mat(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0,
			quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		rows.push_back('{mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768), 1'b0, quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		rows.push_back('{mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
			32767), 1'b0, quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		// saturating off-diagonals with a small root
		rows.push_back('{mat(0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 1),
			1'b0, quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		rows.push_back('{mat(-32768, 32767, -32768, 32767, -32768, 32767, -32768,
			32767, -32768), 1'b0, quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		// strict comparisons on diagonal ties
		rows.push_back('{mat(-8192, 100, -200, 300, -8192, 400, -500, 600, -8192),
			1'b0, quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		rows.push_back('{mat(-9000, 5, 6, 7, -4000, 8, 9, 10, -4000), 1'b0,
			quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		rows.push_back('{mat(-16384, 0, 0, 0, 0, -16384, 0, 16384, 0), 1'b0,
			quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});
		rows.push_back('{mat(0, -16384, 0, 16384, 0, 0, 0, 0, 1), 1'b0,
			quat(0, 0, 0, 0, PIV_TRACE, 1'b0)});

		foreach (rows[n]) begin
			row = rows[n];
			if (row.has_quat && quat_of(row.m) != row.q) begin
				$error("table row %0d: typed result disagrees with model", n);
				n_errors++;
			end
			send_request(row.m);
			sender_gap();
		end
		in_valid <= 1'b0;

		// long output hold-off while requests keep coming
		hold_off = 1'b1;
		for (n = 0; n < 60; n++) send_request(random_matrix());
		hold_off = 1'b0;
		in_valid <= 1'b0;

		// pause until every expected result is back
		wait (quat_queue.size() == 0);
		@(negedge clk);

		for (n = 0; n < N_RANDOM - 60; n++) begin
			if (n == N_RANDOM - 300) calm = 1'b1;
			send_request(random_matrix());
			sender_gap();
		end
		in_valid <= 1'b0;
		sender_done = 1'b1;
	end

	// receiver stall bursts
	initial begin
		int gap;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (200) @(negedge clk);
				out_stall <= 1'b0;
				wait (!hold_off);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				gap = $urandom_range(1, 18);
				repeat (gap) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// result checker
	initial begin
		quat_t exp_q;
		n_results = 0;
		n_degenerate = 0;
		pivot_hits = '{0, 0, 0, 0};
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (quat_queue.size() == 0) begin
					$error("result with no request pending");
					n_errors++;
				end else begin
					exp_q = quat_queue.pop_front();
					n_results++;
					pivot_hits[out_data.pivot]++;
					if (out_data.degenerate) n_degenerate++;
					if (out_data.quat_w !== exp_q.quat_w) begin
						$error("quat_w expected %0d actual %0d", exp_q.quat_w, out_data.quat_w);
						n_errors++;
					end
					if (out_data.quat_x !== exp_q.quat_x) begin
						$error("quat_x expected %0d actual %0d", exp_q.quat_x, out_data.quat_x);
						n_errors++;
					end
					if (out_data.quat_y !== exp_q.quat_y) begin
						$error("quat_y expected %0d actual %0d", exp_q.quat_y, out_data.quat_y);
						n_errors++;
					end
					if (out_data.quat_z !== exp_q.quat_z) begin
						$error("quat_z expected %0d actual %0d", exp_q.quat_z, out_data.quat_z);
						n_errors++;
					end
					if (out_data.pivot !== exp_q.pivot) begin
						$error("pivot expected %0d actual %0d", exp_q.pivot, out_data.pivot);
						n_errors++;
					end
					if (out_data.degenerate !== exp_q.degenerate) begin
						$error("degenerate expected %0d actual %0d", exp_q.degenerate,
							out_data.degenerate);
						n_errors++;
					end
				end
			end
		end
	end

	// end of run
	initial begin
		wait (sender_done);
		wait (quat_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (quat_queue.size() != 0) n_errors++;
		$display("requests %0d, results %0d, degenerate %0d", n_requests, n_results,
			n_degenerate);
		$display("pivot use: trace %0d, x %0d, y %0d, z %0d", pivot_hits[0],
			pivot_hits[1], pivot_hits[2], pivot_hits[3]);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

endmodule
